// ----- sv/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg - shared types and constants
// Widths, command codes and control structs for the leaky trapezoid PID.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DATA_W        = 32;
	localparam int LIMIT_W       = 31;
	localparam int LEAK_W        = 17;
	localparam int LEAK_BITS     = 16;
	localparam int CMD_W         = 2;
	localparam int ADDR_W        = 5;
	localparam int MUL_W         = 34;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_W_DEF     = 2 * MUL_W + 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(65536);
	localparam logic [LEAK_W-1:0]  LEAK_RST  = LEAK_W'(65536);

	// request command codes
	localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_INTEG = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain;
		logic signed [DATA_W-1:0] deriv_gain;
		logic [LIMIT_W-1:0]       integ_limit;
		logic [LEAK_W-1:0]        leak_factor;
	} cfg_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;    // capture a*b
		logic shift_hi;  // product weighs 2^32
		logic acc_en;    // add captured product to accumulator
		logic acc_clr;   // accumulator restarts from zero
	} mac_op_t;

endpackage

// ----- sv/pli_regs.sv -----
// ----------------------------------------------------------------------------
// pli_regs - configuration register file
// APB-style register bank holding gains, integrator clamp and leak factor.
// ----------------------------------------------------------------------------
module pli_regs import pli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam logic [2:0] REG_PROP  = 3'd0;
	localparam logic [2:0] REG_INTEG = 3'd1;
	localparam logic [2:0] REG_DERIV = 3'd2;
	localparam logic [2:0] REG_LIMIT = 3'd3;
	localparam logic [2:0] REG_LEAK  = 3'd4;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.integ_limit <= LIMIT_RST;
			cfg_q.leak_factor <= LEAK_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PROP:  cfg_q.prop_gain   <= pwdata;
				REG_INTEG: cfg_q.integ_gain  <= pwdata;
				REG_DERIV: cfg_q.deriv_gain  <= pwdata;
				REG_LIMIT: cfg_q.integ_limit <= pwdata[LIMIT_W-1:0];
				REG_LEAK:  cfg_q.leak_factor <= pwdata[LEAK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PROP:  prdata = cfg_q.prop_gain;
			REG_INTEG: prdata = cfg_q.integ_gain;
			REG_DERIV: prdata = cfg_q.deriv_gain;
			REG_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_q.integ_limit};
			REG_LEAK:  prdata = {{(DATA_W-LEAK_W){1'b0}}, cfg_q.leak_factor};
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- sv/pli_mac.sv -----
// ----------------------------------------------------------------------------
// pli_mac - shared multiply-accumulate unit
// One registered signed 34x34 multiplier feeding a wide accumulator.
// ----------------------------------------------------------------------------
module pli_mac import pli_pkg::*; #(
	parameter int ACC_W = ACC_W_DEF
) (
	input  logic                     clk,
	input  mac_op_t                  op,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [2*MUL_W-1:0] prod_s1;
	logic                      sh_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   base;

	assign prod_ext = ACC_W'(prod_s1);
	assign term     = sh_s1 ? (prod_ext <<< DATA_W) : prod_ext;
	assign base     = op.acc_clr ? '0 : acc_q;
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (op.mul_en) begin
			prod_s1 <= a * b;
			sh_s1   <= op.shift_hi;
		end
		if (op.acc_en) begin
			acc_q <= base + term;
		end
	end

endmodule

// ----- sv/pid_leaky_trapezoid_integrator.sv -----
// ----------------------------------------------------------------------------
// pid_leaky_trapezoid_integrator - fixed-point PID step, leaky clamped integrator
// Sequencer around one shared multiply-accumulate unit plus APB config bank.
// ----------------------------------------------------------------------------
// One PID step per update request, all values signed Q(32-F).F with F =
// FRAC_BITS (default 16). An update adds the trapezoid (err+prev_err)*dt/2 to
// the integrator (rounded half away from zero), scales it by leak_factor
// (Q1.16, rounded half away from zero), clamps it to +/-integ_limit, then
// returns drive = kp*err + ki*integ + kd*err_rate, rounded half up and
// saturated to 32 bits. A zero step_time returns drive 0 with bad_step set and
// leaves the state alone. Clear requests (command 1: integrator and previous
// error, command 2: integrator only) and the unused code 3 return nothing.
// Sequencing: an update holds in_stall from ST_TSUM until ST_DONE hands on its
// result; every multiply goes through the single registered 34x34 multiplier,
// six products in turn, each followed by an accumulate. Clears stay in ST_IDLE,
// a zero step passes only through ST_DONE. A finished result sits in an output
// register, so the next request is taken while it waits on out_stall. The user
// must see that configuration is written through the APB port only while no
// request is being worked on; the block does not enforce it. pready is tied high.
// ----------------------------------------------------------------------------
module pid_leaky_trapezoid_integrator import pli_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] err_in,
	input  logic signed [DATA_W-1:0] err_rate,
	input  logic [DATA_W-1:0]        step_time,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive,
	output logic                     bad_step,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	// trapezoid magnitude after the divide by 2^(F+1)
	localparam int TMAG_W  = 2 * DATA_W - 1 - FRAC_BITS;
	localparam int ISUM_W  = TMAG_W + 2;
	localparam int AMAG_W  = TMAG_W + 1;
	localparam int HI_W    = AMAG_W - DATA_W;
	localparam int LPROD_W = AMAG_W + LEAK_W;
	localparam int LMAG_W  = LPROD_W + 1 - LEAK_BITS;
	localparam int ACC_W   = (LPROD_W + 2 > 2 * MUL_W + 2) ? LPROD_W + 2 : 2 * MUL_W + 2;
	localparam int TSUM_W  = 2 * DATA_W + 1;

	localparam logic signed [ACC_W-1:0] D_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DATA_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (DATA_W - 1));

	typedef enum logic [4:0] {
		ST_IDLE, ST_TSUM, ST_TMUL, ST_TACC, ST_TRND, ST_TADD, ST_TABS,
		ST_LMUL0, ST_LMUL1, ST_LACC, ST_LRND, ST_CLAMP,
		ST_DMUL0, ST_DMUL1, ST_DMUL2, ST_DACC, ST_DRND, ST_DONE
	} state_t;

	cfg_t cfg;

	state_t                   state_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] integ_q;
	logic signed [DATA_W-1:0] prev_q;

	// per-request working registers
	logic signed [DATA_W-1:0] e_q;
	logic signed [DATA_W-1:0] ed_q;
	logic [DATA_W-1:0]        dt_q;
	logic                     sneg_q;
	logic [DATA_W:0]          smag_q;
	logic [TMAG_W-1:0]        tmag_q;
	logic signed [ISUM_W-1:0] isum_q;
	logic                     aneg_q;
	logic [AMAG_W-1:0]        amag_q;
	logic [LMAG_W-1:0]        lmag_q;
	logic signed [DATA_W-1:0] res_drive_q;
	logic                     res_bad_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     bad_q;

	logic                     in_acc;
	logic                     out_load;

	mac_op_t                  mac_op;
	logic signed [MUL_W-1:0]  mac_a;
	logic signed [MUL_W-1:0]  mac_b;
	logic signed [ACC_W-1:0]  acc;

	// datapath terms
	logic signed [DATA_W:0]   s_sum;
	logic [TSUM_W-1:0]        tsum;
	logic [ISUM_W-1:0]        tterm_u;
	logic signed [ISUM_W-1:0] tterm;
	logic signed [ISUM_W-1:0] isum_next;
	logic signed [ISUM_W-1:0] isum_abs;
	logic [LPROD_W:0]         lsum;
	logic [LIMIT_W-1:0]       lim;
	logic signed [DATA_W-1:0] integ_next;
	logic signed [ACC_W-1:0]  dsum;
	logic signed [ACC_W-1:0]  dtot;
	logic signed [DATA_W-1:0] drive_sat;

	pli_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pli_mac #(.ACC_W(ACC_W)) u_mac (
		.clk (clk),
		.op  (mac_op),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_load  = (state_q == ST_DONE) & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign bad_step  = bad_q;

	// err + prev_err, 33 bits
	assign s_sum = {e_q[DATA_W-1], e_q} + {prev_q[DATA_W-1], prev_q};

	// trapezoid round: (|s|*dt + 2^F) >> (F+1)
	assign tsum = {1'b0, acc[2*DATA_W-1:0]} + (TSUM_W'(1) << FRAC_BITS);

	assign tterm_u   = {{(ISUM_W-TMAG_W){1'b0}}, tmag_q};
	assign tterm     = sneg_q ? -$signed(tterm_u) : $signed(tterm_u);
	assign isum_next = ISUM_W'(integ_q) + tterm;
	assign isum_abs  = isum_q[ISUM_W-1] ? -isum_q : isum_q;

	// leak round: (|acc|*leak + 2^15) >> 16
	assign lsum = {1'b0, acc[LPROD_W-1:0]}
		+ {{(LPROD_W+1-LEAK_BITS){1'b0}}, 1'b1, {(LEAK_BITS-1){1'b0}}};

	// clamp to the limit, then restore the sign
	assign lim        = (lmag_q > LMAG_W'(cfg.integ_limit)) ? cfg.integ_limit
		: lmag_q[LIMIT_W-1:0];
	assign integ_next = aneg_q ? -$signed({1'b0, lim}) : $signed({1'b0, lim});

	// drive: round half up, then saturate
	assign dsum = acc + D_HALF;
	assign dtot = dsum >>> FRAC_BITS;
	always_comb begin
		if (dtot > SAT_HI) begin
			drive_sat = SAT_HI[DATA_W-1:0];
		end else if (dtot < SAT_LO) begin
			drive_sat = SAT_LO[DATA_W-1:0];
		end else begin
			drive_sat = dtot[DATA_W-1:0];
		end
	end

	// shared unit operand select
	always_comb begin
		mac_op = '0;
		mac_a  = '0;
		mac_b  = '0;
		unique case (state_q)
			ST_TMUL: begin
				mac_op.mul_en = 1'b1;
				mac_a = $signed({{(MUL_W-DATA_W-1){1'b0}}, smag_q});
				mac_b = $signed({{(MUL_W-DATA_W){1'b0}}, dt_q});
			end
			ST_TACC, ST_LACC, ST_DACC: begin
				mac_op.acc_en  = 1'b1;
				mac_op.acc_clr = (state_q == ST_TACC);
			end
			ST_LMUL0: begin
				mac_op.mul_en = 1'b1;
				mac_a = $signed({{(MUL_W-DATA_W){1'b0}}, amag_q[DATA_W-1:0]});
				mac_b = $signed({{(MUL_W-LEAK_W){1'b0}}, cfg.leak_factor});
			end
			ST_LMUL1: begin
				mac_op.mul_en   = 1'b1;
				mac_op.shift_hi = 1'b1;
				mac_op.acc_en   = 1'b1;
				mac_op.acc_clr  = 1'b1;
				mac_a = $signed({{(MUL_W-HI_W){1'b0}}, amag_q[AMAG_W-1:DATA_W]});
				mac_b = $signed({{(MUL_W-LEAK_W){1'b0}}, cfg.leak_factor});
			end
			ST_DMUL0: begin
				mac_op.mul_en = 1'b1;
				mac_a = MUL_W'(cfg.prop_gain);
				mac_b = MUL_W'(e_q);
			end
			ST_DMUL1: begin
				mac_op.mul_en  = 1'b1;
				mac_op.acc_en  = 1'b1;
				mac_op.acc_clr = 1'b1;
				mac_a = MUL_W'(cfg.integ_gain);
				mac_b = MUL_W'(integ_q);
			end
			ST_DMUL2: begin
				mac_op.mul_en = 1'b1;
				mac_op.acc_en = 1'b1;
				mac_a = MUL_W'(cfg.deriv_gain);
				mac_b = MUL_W'(ed_q);
			end
			default: ;
		endcase
	end

	// sequencer, stored state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			prev_q      <= '0;
		end else begin
			// result taken and nothing new to load
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (command)
							CMD_UPDATE: begin
								state_q <= (step_time == '0) ? ST_DONE : ST_TSUM;
							end
							CMD_CLR_ALL: begin
								integ_q <= '0;
								prev_q  <= '0;
							end
							CMD_CLR_INTEG: begin
								integ_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_TSUM:  state_q <= ST_TMUL;
				ST_TMUL:  state_q <= ST_TACC;
				ST_TACC:  state_q <= ST_TRND;
				ST_TRND:  state_q <= ST_TADD;
				ST_TADD:  state_q <= ST_TABS;
				ST_TABS:  state_q <= ST_LMUL0;
				ST_LMUL0: state_q <= ST_LMUL1;
				ST_LMUL1: state_q <= ST_LACC;
				ST_LACC:  state_q <= ST_LRND;
				ST_LRND:  state_q <= ST_CLAMP;
				ST_CLAMP: begin
					integ_q <= integ_next;
					state_q <= ST_DMUL0;
				end
				ST_DMUL0: state_q <= ST_DMUL1;
				ST_DMUL1: state_q <= ST_DMUL2;
				ST_DMUL2: state_q <= ST_DACC;
				ST_DACC:  state_q <= ST_DRND;
				ST_DRND: begin
					prev_q  <= e_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q         <= err_in;
			ed_q        <= err_rate;
			dt_q        <= step_time;
			res_drive_q <= '0;
			res_bad_q   <= 1'b1;
		end
		if (state_q == ST_TSUM) begin
			// full 33-bit magnitude, |s| can reach 2^32
			sneg_q <= s_sum[DATA_W];
			smag_q <= s_sum[DATA_W] ? $unsigned(-s_sum) : $unsigned(s_sum);
		end
		if (state_q == ST_TRND) begin
			tmag_q <= tsum[TSUM_W-2:FRAC_BITS+1];
		end
		if (state_q == ST_TADD) begin
			isum_q <= isum_next;
		end
		if (state_q == ST_TABS) begin
			aneg_q <= isum_q[ISUM_W-1];
			amag_q <= isum_abs[AMAG_W-1:0];
		end
		if (state_q == ST_LRND) begin
			lmag_q <= lsum[LPROD_W:LEAK_BITS];
		end
		if (state_q == ST_DRND) begin
			res_drive_q <= drive_sat;
			res_bad_q   <= 1'b0;
		end
		if (out_load) begin
			drive_q <= res_drive_q;
			bad_q   <= res_bad_q;
		end
	end

endmodule

// ----- sv/pli_checker.sv -----
// ----------------------------------------------------------------------------
// pli_checker - port-level assertions
// Checks result and request handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module pli_checker import pli_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [CMD_W-1:0]         command,
	input logic [DATA_W-1:0]        step_time,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] drive,
	input logic                     bad_step
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive) && $stable(bad_step))
		else $error("result changed while stalled");

	// a zero step always reports zero drive
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_step |-> drive == '0)
		else $error("bad step with nonzero drive");

	// a real update keeps the request side busy
	a_upd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CMD_UPDATE && step_time != '0 |=> in_stall)
		else $error("update not worked on");

	// clears and unused codes finish at once and give no result
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command != CMD_UPDATE && !out_valid
		|=> !in_stall && !out_valid)
		else $error("clear request produced a result or stalled");

endmodule

bind pid_leaky_trapezoid_integrator pli_checker u_pli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.command   (command),
	.step_time (step_time),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive),
	.bad_step  (bad_step)
);
